FILE: src/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion pipeline.
// No dependencies; imported by every module of the block.
package rmq_pkg;

  localparam int N_LANES = 4;
  localparam int QUAT_W = 16;
  localparam logic [14:0] MAG_MAX = 15'h7fff;

  typedef enum logic [1:0] {
    COMP_W,
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_e;

endpackage

FILE: src/rmq_sqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
// Several lanes share the handshake and carry a sideband along; uses rmq_pkg.
module rmq_sqrt import rmq_pkg::*; #(
  parameter int LANES = N_LANES,
  parameter int RW = 32,
  parameter int SBW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [LANES-1:0][RW-1:0]         rad_i,
  input  logic [SBW-1:0]                   sb_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [LANES-1:0][RW/2-1:0]       root_o,
  output logic [SBW-1:0]                   sb_o
);

  localparam int AW = RW / 2;
  localparam int NS = AW;
  localparam int RMW = AW + 2;

  logic                          v_q    [NS];
  logic [LANES-1:0][RMW-1:0]     rem_q  [NS];
  logic [LANES-1:0][AW-1:0]      root_q [NS];
  logic [LANES-1:0][RW-1:0]      rad_q  [NS];
  logic [SBW-1:0]                sb_q   [NS];
  logic                          rdy    [NS+1];

  assign rdy[NS] = out_ready_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                      v_in;
    logic [LANES-1:0][RMW-1:0] rem_in, rem_d;
    logic [LANES-1:0][AW-1:0]  root_in, root_d;
    logic [LANES-1:0][RW-1:0]  rad_in, rad_d;
    logic [SBW-1:0]            sb_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_comb begin
      logic [RMW-1:0] nr;
      logic [RMW-1:0] tr;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        nr = {rem_in[l][RMW-3:0], rad_in[l][RW-1:RW-2]};
        tr = {root_in[l], 2'b01};
        ge = nr >= tr;
        rem_d[l]  = ge ? nr - tr : nr;
        root_d[l] = {root_in[l][AW-2:0], ge};
        rad_d[l]  = {rad_in[l][RW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_d;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign root_o      = root_q[NS-1];
  assign sb_o        = sb_q[NS-1];

endmodule

FILE: src/rmq_div.sv
// Pipelined restoring divider, one quotient bit per register stage, shared divisor.
// Numerator must stay below divisor << QW; uses rmq_pkg.
module rmq_div import rmq_pkg::*; #(
  parameter int LANES = N_LANES,
  parameter int DW = 16,
  parameter int QW = 15,
  parameter int SBW = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [LANES-1:0][DW+QW-1:0]     num_i,
  input  logic [DW-1:0]                   den_i,
  input  logic [SBW-1:0]                  sb_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [LANES-1:0][QW-1:0]        quo_o,
  output logic [SBW-1:0]                  sb_o
);

  localparam int NMW = DW + QW;

  logic                         v_q   [QW];
  logic [LANES-1:0][DW-1:0]     rem_q [QW];
  logic [LANES-1:0][QW-1:0]     nl_q  [QW];
  logic [LANES-1:0][QW-1:0]     quo_q [QW];
  logic [DW-1:0]                den_q [QW];
  logic [SBW-1:0]               sb_q  [QW];
  logic                         rdy   [QW+1];

  assign rdy[QW] = out_ready_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     v_in;
    logic [LANES-1:0][DW-1:0] rem_in, rem_d;
    logic [LANES-1:0][QW-1:0] nl_in, nl_d, quo_in, quo_d;
    logic [DW-1:0]            den_in;
    logic [SBW-1:0]           sb_in;

    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign quo_in = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = num_i[l][NMW-1:QW];
        assign nl_in[l]  = num_i[l][QW-1:0];
      end
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign nl_in  = nl_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_comb begin
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        t    = {rem_in[l], nl_in[l][QW-1]};
        diff = t - {1'b0, den_in};
        ge   = t >= {1'b0, den_in};
        rem_d[l] = ge ? diff[DW-1:0] : t[DW-1:0];
        quo_d[l] = {quo_in[l][QW-2:0], ge};
        nl_d[l]  = {nl_in[l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        rem_q[k] <= rem_d;
        nl_q[k]  <= nl_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[QW-1];
  assign quo_o       = quo_q[QW-1];
  assign sb_o        = sb_q[QW-1];

endmodule

FILE: src/rotation_matrix_to_quaternion.sv
// Converts a 3x3 rotation matrix to a unit quaternion, one matrix per clock when
// the output is drained. Its depth comes mostly from the two bit-serial square
// root pipelines, the first on the padded radicand width RW with AW = RW/2 root
// bits, and from the bit-per-stage divider.
// Throughput is one transaction per cycle without stalls; every stage holds its
// data under backpressure and a bubble anywhere is filled by the next matrix.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       m00_i,
  input  logic signed [15:0]       m01_i,
  input  logic signed [15:0]       m02_i,
  input  logic signed [15:0]       m10_i,
  input  logic signed [15:0]       m11_i,
  input  logic signed [15:0]       m12_i,
  input  logic signed [15:0]       m20_i,
  input  logic signed [15:0]       m21_i,
  input  logic signed [15:0]       m22_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [QUAT_W-1:0] quat_w_o,
  output logic signed [QUAT_W-1:0] quat_x_o,
  output logic signed [QUAT_W-1:0] quat_y_o,
  output logic signed [QUAT_W-1:0] quat_z_o
);

  localparam int SW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int RW  = ((SW + FRAC_BITS - 2 + 1) / 2) * 2;
  localparam int AW  = RW / 2;
  localparam int SQW = 2 * AW + 2;
  localparam int NW  = AW + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int DNW = NW + QW;
  localparam logic [SW:0] ONE_C = {{SW{1'b0}}, 1'b1} << FRAC_BITS;

  // ---------------- stage A: diagonal sums and sign sources
  logic signed [SW:0] e00, e11, e22;
  logic signed [SW:0] s_d [N_LANES];
  logic [N_LANES-1:0][RW-1:0] rad_d, rad_q;
  logic [5:0] flg_d, flg_q;
  logic va_q, rdy_a, s0_in_ready;

  assign e00 = {{(SW-15){m00_i[15]}}, m00_i};
  assign e11 = {{(SW-15){m11_i[15]}}, m11_i};
  assign e22 = {{(SW-15){m22_i[15]}}, m22_i};

  always_comb begin
    logic signed [16:0] d75, d26, d31, a31, a26, a75;
    s_d[0] =  e00 + e11 + e22 + $signed(ONE_C);
    s_d[1] =  e00 - e11 - e22 + $signed(ONE_C);
    s_d[2] = -e00 + e11 - e22 + $signed(ONE_C);
    s_d[3] = -e00 - e11 + e22 + $signed(ONE_C);
    for (int i = 0; i < N_LANES; i++) begin
      rad_d[i] = s_d[i][SW] ? '0
               : ({{(RW-SW){1'b0}}, s_d[i][SW-1:0]} << (FRAC_BITS - 2));
    end
    d75 = {m21_i[15], m21_i} - {m12_i[15], m12_i};
    d26 = {m02_i[15], m02_i} - {m20_i[15], m20_i};
    d31 = {m10_i[15], m10_i} - {m01_i[15], m01_i};
    a31 = {m10_i[15], m10_i} + {m01_i[15], m01_i};
    a26 = {m02_i[15], m02_i} + {m20_i[15], m20_i};
    a75 = {m21_i[15], m21_i} + {m12_i[15], m12_i};
    flg_d = {a75[16], a26[16], a31[16], d31[16], d26[16], d75[16]};
  end

  assign rdy_a      = !va_q || s0_in_ready;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_valid_i) begin
      rad_q <= rad_d;
      flg_q <= flg_d;
    end
  end

  // ---------------- component magnitudes
  logic s0_out_valid, rdy_b;
  logic [N_LANES-1:0][AW-1:0] mag_a;
  logic [5:0] flg_b;

  rmq_sqrt #(.LANES(N_LANES), .RW(RW), .SBW(6)) u_sqrt_comp (
    .clk_i, .rst_ni,
    .in_valid_i (va_q),
    .in_ready_o (s0_in_ready),
    .rad_i      (rad_q),
    .sb_i       (flg_q),
    .out_valid_o(s0_out_valid),
    .out_ready_i(rdy_b),
    .root_o     (mag_a),
    .sb_o       (flg_b)
  );

  // ---------------- stage B: pick largest, signs, squares
  comp_e big;
  logic [N_LANES-1:0] neg_d, neg_b_q;
  logic [N_LANES-1:0][AW-1:0] a_b_q;
  logic [2*AW-1:0] sqr_q [N_LANES];
  logic vb_q, rdy_c;

  always_comb begin
    big = COMP_W;
    if (mag_a[1] > mag_a[big]) big = COMP_X;
    if (mag_a[2] > mag_a[big]) big = COMP_Y;
    if (mag_a[3] > mag_a[big]) big = COMP_Z;
    // flags: 0 d75, 1 d26, 2 d31, 3 a31, 4 a26, 5 a75
    case (big)
      COMP_W:  neg_d = {flg_b[2], flg_b[1], flg_b[0], 1'b0};
      COMP_X:  neg_d = {flg_b[4], flg_b[3], 1'b0, flg_b[0]};
      COMP_Y:  neg_d = {flg_b[5], 1'b0, flg_b[3], flg_b[1]};
      COMP_Z:  neg_d = {1'b0, flg_b[5], flg_b[4], flg_b[2]};
      default: neg_d = '0;
    endcase
  end

  assign rdy_b = !vb_q || rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= s0_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && s0_out_valid) begin
      a_b_q   <= mag_a;
      neg_b_q <= neg_d;
      for (int i = 0; i < N_LANES; i++) begin
        sqr_q[i] <= {{AW{1'b0}}, mag_a[i]} * {{AW{1'b0}}, mag_a[i]};
      end
    end
  end

  // ---------------- stage C: sum of squares
  logic vc_q, s1_in_ready;
  logic [SQW-1:0] sum_q;
  logic [N_LANES-1:0][AW-1:0] a_c_q;
  logic [N_LANES-1:0] neg_c_q;

  assign rdy_c = !vc_q || s1_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      sum_q   <= {2'b00, sqr_q[0]} + {2'b00, sqr_q[1]}
               + {2'b00, sqr_q[2]} + {2'b00, sqr_q[3]};
      a_c_q   <= a_b_q;
      neg_c_q <= neg_b_q;
    end
  end

  // ---------------- norm
  logic s1_out_valid, rdy_d;
  logic [0:0][NW-1:0] norm;
  logic [N_LANES*AW+N_LANES-1:0] sb_n;
  logic [N_LANES-1:0][AW-1:0] a_n;
  logic [N_LANES-1:0] neg_n;

  rmq_sqrt #(.LANES(1), .RW(SQW), .SBW(N_LANES*AW+N_LANES)) u_sqrt_norm (
    .clk_i, .rst_ni,
    .in_valid_i (vc_q),
    .in_ready_o (s1_in_ready),
    .rad_i      (sum_q),
    .sb_i       ({neg_c_q, a_c_q}),
    .out_valid_o(s1_out_valid),
    .out_ready_i(rdy_d),
    .root_o     (norm),
    .sb_o       (sb_n)
  );

  assign a_n   = sb_n[N_LANES*AW-1:0];
  assign neg_n = sb_n[N_LANES*AW+N_LANES-1:N_LANES*AW];

  // ---------------- stage D: rounded numerators
  logic vd_q, dv_in_ready;
  logic [N_LANES-1:0][DNW-1:0] num_q;
  logic [NW-1:0] den_q;
  logic [N_LANES-1:0] neg_d_q;
  logic [NW-1:0] den_d;

  assign den_d = (norm[0] == '0) ? {{(NW-1){1'b0}}, 1'b1} : norm[0];
  assign rdy_d = !vd_q || dv_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (rdy_d) begin
      vd_q <= s1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && s1_out_valid) begin
      den_q   <= den_d;
      neg_d_q <= neg_n;
      for (int i = 0; i < N_LANES; i++) begin
        num_q[i] <= {2'b00, a_n[i], {FRAC_BITS{1'b0}}}
                  + {{(QW+1){1'b0}}, norm[0][NW-1:1]};
      end
    end
  end

  // ---------------- normalize
  logic dv_out_valid, rdy_e;
  logic [N_LANES-1:0][QW-1:0] quo;
  logic [N_LANES-1:0] neg_e;

  rmq_div #(.LANES(N_LANES), .DW(NW), .QW(QW), .SBW(N_LANES)) u_div (
    .clk_i, .rst_ni,
    .in_valid_i (vd_q),
    .in_ready_o (dv_in_ready),
    .num_i      (num_q),
    .den_i      (den_q),
    .sb_i       (neg_d_q),
    .out_valid_o(dv_out_valid),
    .out_ready_i(rdy_e),
    .quo_o      (quo),
    .sb_o       (neg_e)
  );

  // ---------------- stage E: saturate, apply sign, output register
  logic vo_q;
  logic [N_LANES-1:0][QUAT_W-1:0] q_d, q_q;

  always_comb begin
    logic [31:0] qx;
    logic [14:0] mag;
    for (int i = 0; i < N_LANES; i++) begin
      qx  = 32'(quo[i]);
      mag = (qx > 32'(MAG_MAX)) ? MAG_MAX : qx[14:0];
      q_d[i] = neg_e[i] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    end
  end

  assign rdy_e = !vo_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_e) begin
      vo_q <= dv_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && dv_out_valid) begin
      q_q <= q_d;
    end
  end

  assign out_valid_o = vo_q;
  assign quat_w_o    = q_q[0];
  assign quat_x_o    = q_q[1];
  assign quat_y_o    = q_q[2];
  assign quat_z_o    = q_q[3];

  // The four diagonal sums add to 4.0, so the squared norm is never zero.
  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> sum_q != '0) else $error("sum of squares is zero");

  // The largest component always keeps a positive sign.
  a_big_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_out_valid |-> !neg_d[big]) else $error("largest component negated");

  // Each component is at most the norm, so a quotient never exceeds one.
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_out_valid |-> (32'(quo[0]) <= (32'd1 << FRAC_BITS))
                  && (32'(quo[1]) <= (32'd1 << FRAC_BITS))
                  && (32'(quo[2]) <= (32'd1 << FRAC_BITS))
                  && (32'(quo[3]) <= (32'd1 << FRAC_BITS)))
    else $error("normalized component above one");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for rotation_matrix_to_quaternion: directed and random matrices,
// with results predicted in fixed point and compared per component in order.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`timescale 1ns / 100ps

module tb;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  typedef logic signed [15:0] q14_t;
  typedef struct packed {
    q14_t w;
    q14_t x;
    q14_t y;
    q14_t z;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  q14_t m_in [9];
  logic in_ready_o, out_valid_o;
  q14_t quat_w_o, quat_x_o, quat_y_o, quat_z_o;

  quat_t expected_quats[$];
  bit failed = 1'b0;
  bit calm = 1'b0;  // no idling on either side while set
  int unsigned cycles = 0;

  always #10 clk_i = ~clk_i;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .m00_i(m_in[0]), .m01_i(m_in[1]), .m02_i(m_in[2]),
    .m10_i(m_in[3]), .m11_i(m_in[4]), .m12_i(m_in[5]),
    .m20_i(m_in[6]), .m21_i(m_in[7]), .m22_i(m_in[8]),
    .out_valid_o, .out_ready_i, .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o
  );

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic quat_t matrix_to_quat(q14_t mx [9]);
    longint m [9];
    longint diag [4];
    longint unsigned mag [4];
    longint unsigned sumsq, norm, scaled;
    bit neg [4];
    int top;
    quat_t q;
    q14_t comp [4];
    for (int i = 0; i < 9; i++) m[i] = mx[i];
    diag[COMP_W] = m[0] + m[4] + m[8] + (64'sd1 << FRAC);
    diag[COMP_X] = m[0] - m[4] - m[8] + (64'sd1 << FRAC);
    diag[COMP_Y] = -m[0] + m[4] - m[8] + (64'sd1 << FRAC);
    diag[COMP_Z] = -m[0] - m[4] + m[8] + (64'sd1 << FRAC);
    for (int i = 0; i < 4; i++) begin
      if (diag[i] < 0) diag[i] = 0;
      mag[i] = floor_sqrt(longint'(diag[i]) << (FRAC - 2));
      neg[i] = 1'b0;
    end
    top = COMP_W;
    for (int i = 1; i < 4; i++) if (mag[i] > mag[top]) top = i;
    case (comp_e'(top))
      COMP_W: begin
        neg[COMP_X] = (m[7] - m[5]) < 0;
        neg[COMP_Y] = (m[2] - m[6]) < 0;
        neg[COMP_Z] = (m[3] - m[1]) < 0;
      end
      COMP_X: begin
        neg[COMP_W] = (m[7] - m[5]) < 0;
        neg[COMP_Y] = (m[3] + m[1]) < 0;
        neg[COMP_Z] = (m[2] + m[6]) < 0;
      end
      COMP_Y: begin
        neg[COMP_W] = (m[2] - m[6]) < 0;
        neg[COMP_X] = (m[3] + m[1]) < 0;
        neg[COMP_Z] = (m[7] + m[5]) < 0;
      end
      default: begin
        neg[COMP_W] = (m[3] - m[1]) < 0;
        neg[COMP_X] = (m[6] + m[2]) < 0;
        neg[COMP_Y] = (m[7] + m[5]) < 0;
      end
    endcase
    sumsq = 0;
    for (int i = 0; i < 4; i++) sumsq += mag[i] * mag[i];
    norm = floor_sqrt(sumsq);
    if (norm == 0) norm = 1;
    for (int i = 0; i < 4; i++) begin
      scaled = ((mag[i] << FRAC) + (norm >> 1)) / norm;
      if (scaled > 32767) scaled = 32767;
      comp[i] = neg[i] ? -q14_t'(scaled) : q14_t'(scaled);
    end
    q.w = comp[COMP_W];
    q.x = comp[COMP_X];
    q.y = comp[COMP_Y];
    q.z = comp[COMP_Z];
    return q;
  endfunction

  // Drive one matrix and hold it until the DUT accepts it.
  task automatic send_matrix(q14_t mx [9]);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) m_in[i] <= mx[i];
    do @(posedge clk_i); while (!in_ready_o);
    expected_quats.push_back(matrix_to_quat(mx));
  endtask

  task automatic send_values(int v0, int v1, int v2, int v3, int v4, int v5,
                             int v6, int v7, int v8);
    q14_t mx [9];
    mx = '{q14_t'(v0), q14_t'(v1), q14_t'(v2), q14_t'(v3), q14_t'(v4),
           q14_t'(v5), q14_t'(v6), q14_t'(v7), q14_t'(v8)};
    send_matrix(mx);
  endtask

  function automatic q14_t to_q14(real r);
    real s;
    s = r * 16384.0;
    s = (s >= 0.0) ? s + 0.5 : s - 0.5;
    if (s > 32767.0) s = 32767.0;
    if (s < -32768.0) s = -32768.0;
    return q14_t'($rtoi(s));
  endfunction

  // Rotation matrix from a random unit quaternion, with a little noise.
  task automatic send_rotation();
    real w, x, y, z, len;
    real r [9];
    q14_t mx [9];
    w = real'($urandom_range(65535)) - 32768.0;
    x = real'($urandom_range(65535)) - 32768.0;
    y = real'($urandom_range(65535)) - 32768.0;
    z = real'($urandom_range(65535)) - 32768.0;
    if ($urandom_range(3) == 0) w = 0.0;  // half-turns exercise the other pivots
    len = $sqrt(w * w + x * x + y * y + z * z) + 1.0e-9;
    w /= len; x /= len; y /= len; z /= len;
    r = '{1.0 - 2.0 * (y * y + z * z), 2.0 * (x * y - w * z), 2.0 * (x * z + w * y),
          2.0 * (x * y + w * z), 1.0 - 2.0 * (x * x + z * z), 2.0 * (y * z - w * x),
          2.0 * (x * z - w * y), 2.0 * (y * z + w * x), 1.0 - 2.0 * (x * x + y * y)};
    for (int i = 0; i < 9; i++)
      mx[i] = to_q14(r[i]) + q14_t'(int'($urandom_range(6)) - 3);
    send_matrix(mx);
  endtask

  task automatic send_noise();
    q14_t mx [9];
    for (int i = 0; i < 9; i++) mx[i] = q14_t'($urandom);
    send_matrix(mx);
  endtask

  task automatic test_directed();
    send_values(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);       // identity
    send_values(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);     // half-turn about x
    send_values(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);     // half-turn about y
    send_values(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);     // half-turn about z
    send_values(0, 0, 0, 0, 0, 0, 0, 0, 0);                   // four-way tie
    send_values(0, 100, -100, 100, 0, 100, -100, 100, 0);     // zero sign sources
    send_values(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_values(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_values(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
    send_values(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
    send_values(32767, 0, 0, 0, -32768, 0, 0, 0, -32768);     // clamped diagonal sums
    send_values(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);      // quarter-turn about z
    send_values(16384, 0, 0, 0, 0, -16384, 0, 16384, 0);      // quarter-turn about x
    send_values(0, 5, 7, -5, 0, 9, -7, -9, 0);
    send_values(8192, 0, 0, 0, 8192, 0, 0, 0, -16384);        // tie between x and y
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      calm = (n >= 500 && n < 800);
      if ($urandom_range(99) < 75) send_rotation();
      else send_noise();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_quats.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result with nothing expected: w=%0d x=%0d y=%0d z=%0d",
                 $time, quat_w_o, quat_x_o, quat_y_o, quat_z_o);
      end else begin
        want = expected_quats.pop_front();
        if (quat_w_o !== want.w) begin
          failed = 1'b1;
          $display("%0t: quat_w expected %0d actual %0d", $time, want.w, quat_w_o);
        end
        if (quat_x_o !== want.x) begin
          failed = 1'b1;
          $display("%0t: quat_x expected %0d actual %0d", $time, want.x, quat_x_o);
        end
        if (quat_y_o !== want.y) begin
          failed = 1'b1;
          $display("%0t: quat_y expected %0d actual %0d", $time, want.y, quat_y_o);
        end
        if (quat_z_o !== want.z) begin
          failed = 1'b1;
          $display("%0t: quat_z expected %0d actual %0d", $time, want.z, quat_z_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 9; i++) m_in[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1435);
    in_valid_i <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed && expected_quats.size() == 0)
      $display("rotation_matrix_to_quaternion verification clean");
    else
      $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

endmodule
